// File: rtl/pxa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the pixel to glyph stream.
// No dependencies; every other file in rtl/ imports this package.
package pxa_pkg;

  // Dimension limits and register reset values
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CNT_W       = 12;
  localparam logic [12:0] MAX_DIM     = 13'd4096;
  localparam logic [12:0] RST_WIDTH   = 13'd640;
  localparam logic [12:0] RST_HEIGHT  = 13'd480;

  // Column step needs up to 4096/120 = 34, row step up to 4096/40 = 102
  localparam int unsigned XSTEP_W     = 6;
  localparam int unsigned YSTEP_W     = 7;

  // Reciprocals: floor(w/120) = (w*4370) >> 19, floor(h/40) = (h*3277) >> 17,
  // both exact for values up to 4096
  localparam logic [12:0] XS_RECIP    = 13'd4370;
  localparam int unsigned XS_SHIFT    = 19;
  localparam logic [12:0] YS_RECIP    = 13'd3277;
  localparam int unsigned YS_SHIFT    = 17;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // BT.601 luma weights in 16-bit fixed point
  localparam logic [15:0] LUMA_R      = 16'd19595;
  localparam logic [15:0] LUMA_G      = 16'd38470;
  localparam logic [15:0] LUMA_B      = 16'd7471;

  // Ramp and line break
  localparam int unsigned RAMP_LEN    = 70;
  localparam logic [6:0]  RAMP_TOP    = 7'd69;
  localparam logic [6:0]  GLYPH_LF    = 7'd10;
  localparam logic [8*RAMP_LEN-1:0] RAMP_STR =
    "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^\140'. ";

  // Queue between front and back
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pxa_pix_t;

  typedef struct packed {
    logic [6:0] glyph;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       line_break;
    logic       last_of_run;
  } pxa_res_t;

  // One classified pixel waiting for the back end
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] luma;
    logic       sampled;
    logic       brk;
  } pxa_job_t;

  // 0 reads as 1, anything above the limit reads as the limit
  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) r = 13'd1;
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  function automatic logic [XSTEP_W-1:0] x_step(input logic [12:0] w);
    logic [25:0] p;
    logic [6:0]  q;
    p = 26'(w) * 26'(XS_RECIP);
    q = p[25:XS_SHIFT];
    return (q == 7'd0) ? XSTEP_W'(1) : q[XSTEP_W-1:0];
  endfunction

  function automatic logic [YSTEP_W-1:0] y_step(input logic [12:0] h);
    logic [25:0] p;
    logic [8:0]  q;
    p = 26'(h) * 26'(YS_RECIP);
    q = p[25:YS_SHIFT];
    return (q == 9'd0) ? YSTEP_W'(1) : q[YSTEP_W-1:0];
  endfunction

endpackage

// File: rtl/pixel_to_ascii_glyph_stream_top.sv
`timescale 1ns / 1ps
// Top level of the pixel to ASCII glyph stream.
// Depends on pxa_pkg, pxa_front, pxa_fifo and pxa_back.
//
// Pixels enter on the in_* valid/ready channel in raster order, one word per
// pixel. Sampled pixels leave as a glyph word with the pixel colour on the
// out_* valid/ready channel; the last pixel of a sampled row also produces a
// line break word (glyph 10, colour 0), which follows the glyph word if both
// occur. last_of_run marks the final word caused by a pixel.
// Image width and height are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while the block is idle (the block does not
// enforce it); a write restarts the raster at column 0, row 0. An accepted
// pixel's words pass through the queue into the output register. The front
// end takes one pixel per cycle while the queue has room; the back end sends
// one word per cycle while the receiver takes it, a pixel with two words
// holding it for both. A four-entry queue between front and back absorbs
// these bursts. When the receiver stalls the output word holds, the queue
// fills and then in_ready_o drops. Reset sets width 640, height 480, empties
// the queue and output register, and starts at column 0, row 0.
module pixel_to_ascii_glyph_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pxa_pkg::pxa_pix_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pxa_pkg::pxa_res_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pxa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pxa_pkg::DIM_W-1:0]     cfg_data_i
);
  import pxa_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  pxa_job_t push_data, pop_data;

  pxa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pxa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pxa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/pxa_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, raster position counters, sample
// classification and luma. Depends on pxa_pkg.
module pxa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pxa_pkg::pxa_pix_t             in_data_i,
  input  logic                          cfg_we_i,
  input  logic [pxa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pxa_pkg::DIM_W-1:0]     cfg_data_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output pxa_pkg::pxa_job_t             push_data_o
);
  import pxa_pkg::*;

  logic [DIM_W-1:0]   w_q, w_d, h_q, h_d;
  logic [XSTEP_W-1:0] xs_q, xs_d, cph_q, cph_d;
  logic [YSTEP_W-1:0] ys_q, ys_d, rph_q, rph_d;
  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;

  logic               accept;
  logic               row_sampled, sampled, row_end, brk;
  logic [DIM_W-1:0]   col_inc, row_inc;
  logic [23:0]        wsum;

  assign in_ready_o  = push_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // Classification of the current position
  assign col_inc     = {1'b0, col_q} + DIM_W'(1);
  assign row_inc     = {1'b0, row_q} + DIM_W'(1);
  assign row_sampled = (rph_q == '0);
  assign sampled     = row_sampled && (cph_q == '0);
  assign row_end     = (col_inc >= w_q);
  assign brk         = row_sampled && row_end;

  // Luma, weights sum to 65536 so the top byte is 0..255
  assign wsum = 24'(LUMA_R) * 24'(in_data_i.red)
              + 24'(LUMA_G) * 24'(in_data_i.green)
              + 24'(LUMA_B) * 24'(in_data_i.blue);

  assign push_valid_o        = accept && (sampled || brk);
  assign push_data_o.red     = in_data_i.red;
  assign push_data_o.green   = in_data_i.green;
  assign push_data_o.blue    = in_data_i.blue;
  assign push_data_o.luma    = wsum[23:16];
  assign push_data_o.sampled = sampled;
  assign push_data_o.brk     = brk;

  // Register writes and counter stepping
  always_comb begin
    w_d   = w_q;
    h_d   = h_q;
    xs_d  = xs_q;
    ys_d  = ys_q;
    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH: begin
          w_d  = clamp_dim(cfg_data_i);
          xs_d = x_step(clamp_dim(cfg_data_i));
        end
        REG_HEIGHT: begin
          h_d  = clamp_dim(cfg_data_i);
          ys_d = y_step(clamp_dim(cfg_data_i));
        end
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
      cph_d = '0;
      rph_d = '0;
    end else if (accept) begin
      if (row_end) begin
        col_d = '0;
        cph_d = '0;
        if (row_inc >= h_q) begin
          row_d = '0;
          rph_d = '0;
        end else begin
          row_d = row_inc[CNT_W-1:0];
          rph_d = (rph_q == ys_q - YSTEP_W'(1)) ? '0 : rph_q + YSTEP_W'(1);
        end
      end else begin
        col_d = col_inc[CNT_W-1:0];
        cph_d = (cph_q == xs_q - XSTEP_W'(1)) ? '0 : cph_q + XSTEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= RST_WIDTH;
      h_q   <= RST_HEIGHT;
      xs_q  <= x_step(RST_WIDTH);
      ys_q  <= y_step(RST_HEIGHT);
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else begin
      w_q   <= w_d;
      h_q   <= h_d;
      xs_q  <= xs_d;
      ys_q  <= ys_d;
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

// File: rtl/pxa_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified pixels between front and back end.
// Depends on pxa_pkg.
module pxa_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  pxa_pkg::pxa_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output pxa_pkg::pxa_job_t pop_data_o
);
  import pxa_pkg::*;

  pxa_job_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count
  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// File: rtl/pxa_back.sv
`timescale 1ns / 1ps
// Back end: turns a queued pixel into its glyph word and/or line break word,
// with the output register. Depends on pxa_pkg.
module pxa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  pxa_pkg::pxa_job_t job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pxa_pkg::pxa_res_t out_data_o
);
  import pxa_pkg::*;

  logic       out_valid_q, out_valid_d;
  pxa_res_t   out_q, out_d;
  logic       phase_q, phase_d;   // 1: glyph of head job already sent
  logic       emit_glyph, last, issue, can_load;
  logic [14:0] m, idx_sum;
  logic [6:0]  idx;
  logic [7:0]  ch;

  // Ramp index = floor(luma*69/255), divide by 255 as (x + (x>>8) + 1) >> 8
  assign m       = 15'(job_i.luma) * 15'(RAMP_TOP);
  assign idx_sum = m + (m >> 8) + 15'd1;
  assign idx     = idx_sum[14:8];
  assign ch      = RAMP_STR[8*(RAMP_TOP - idx) +: 8];

  assign emit_glyph  = job_i.sampled && !phase_q;
  assign last        = emit_glyph ? !job_i.brk : 1'b1;
  assign can_load    = !out_valid_q || out_ready_i;
  assign issue       = job_valid_i && can_load;
  assign job_ready_o = issue && last;

  // Next output word
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    phase_d     = phase_q;
    if (issue) begin
      out_valid_d = 1'b1;
      phase_d     = !last;
      if (emit_glyph) begin
        out_d.glyph       = ch[6:0];
        out_d.out_red     = job_i.red;
        out_d.out_green   = job_i.green;
        out_d.out_blue    = job_i.blue;
        out_d.line_break  = 1'b0;
        out_d.last_of_run = last;
      end else begin
        out_d.glyph       = GLYPH_LF;
        out_d.out_red     = '0;
        out_d.out_green   = '0;
        out_d.out_blue    = '0;
        out_d.line_break  = 1'b1;
        out_d.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/pxa_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the glyph stream output, bound to the top level.
// Depends on pxa_pkg and pixel_to_ascii_glyph_stream_top.
module pxa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pxa_pkg::pxa_res_t out_data_o
);
  import pxa_pkg::*;

  // A stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // Line break words are fixed and always close the run
  a_brk_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_break |->
      out_data_o.glyph == GLYPH_LF && out_data_o.out_red == 8'd0 &&
      out_data_o.out_green == 8'd0 && out_data_o.out_blue == 8'd0 &&
      out_data_o.last_of_run)
    else $error("malformed line break word");

  // A glyph that does not close its run is followed at once by the break
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=>
      out_valid_o && out_data_o.line_break)
    else $error("glyph without its line break");

  // Glyph words carry a printable ramp character
  a_glyph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.line_break |->
      out_data_o.glyph >= 7'd32 && out_data_o.glyph <= 7'd126)
    else $error("glyph outside printable range");

endmodule

bind pixel_to_ascii_glyph_stream_top pxa_checker u_pxa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/sv/pixel_to_ascii_glyph_stream_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pixel_to_ascii_glyph_stream_top.
// Depends on pxa_pkg and the RTL under rtl/; predicts glyph words locally.
module pixel_to_ascii_glyph_stream_top_tb;
  import pxa_pkg::*;

  // Predictor constants: BT.601 weights in 16-bit fixed point, ramp, targets
  localparam int unsigned WT_RED      = 19595;
  localparam int unsigned WT_GREEN    = 38470;
  localparam int unsigned WT_BLUE     = 7471;
  localparam int unsigned RAMP_LAST   = 69;
  localparam int unsigned COLS_TARGET = 120;
  localparam int unsigned ROWS_TARGET = 40;
  localparam logic [8*70-1:0] GLYPH_RAMP =
    "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^\140'. ";

  localparam int unsigned RAND_ITEMS   = 800;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  pxa_pix_t             in_data = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  pxa_res_t             out_data_o;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  // Stimulus and expectation stores
  pxa_pix_t    pixel_q[$];
  pxa_res_t    pending_glyphs[$];
  pxa_res_t    want;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  // Predictor copy of the dimensions and raster position
  logic [DIM_W-1:0] img_w = 13'd640;
  logic [DIM_W-1:0] img_h = 13'd480;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  pixel_to_ascii_glyph_stream_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Expected words for one pixel; advances the raster position
  function automatic void predict_glyphs(input pxa_pix_t px);
    int unsigned w, h, xs, ys, luma, lvl;
    bit          row_hit, pix_hit, row_end;
    logic [7:0]  ch;
    pxa_res_t    r;
    w = (img_w == '0) ? 1 : ((img_w > MAX_DIM) ? 32'(MAX_DIM) : 32'(img_w));
    h = (img_h == '0) ? 1 : ((img_h > MAX_DIM) ? 32'(MAX_DIM) : 32'(img_h));
    xs = w / COLS_TARGET;
    if (xs == 0) xs = 1;
    ys = h / ROWS_TARGET;
    if (ys == 0) ys = 1;
    row_hit = (row_pos % ys) == 0;
    pix_hit = row_hit && ((col_pos % xs) == 0);
    row_end = (col_pos + 1) >= w;
    if (pix_hit) begin
      luma = (WT_RED * 32'(px.red) + WT_GREEN * 32'(px.green)
              + WT_BLUE * 32'(px.blue)) >> 16;
      lvl = (luma * RAMP_LAST) / 255;
      if (lvl > RAMP_LAST) lvl = RAMP_LAST;
      ch = GLYPH_RAMP[8*(RAMP_LAST-lvl) +: 8];
      r.glyph       = ch[6:0];
      r.out_red     = px.red;
      r.out_green   = px.green;
      r.out_blue    = px.blue;
      r.line_break  = 1'b0;
      r.last_of_run = !(row_hit && row_end);
      pending_glyphs.push_back(r);
    end
    if (row_hit && row_end) begin
      r.glyph       = GLYPH_LF;
      r.out_red     = 8'd0;
      r.out_green   = 8'd0;
      r.out_blue    = 8'd0;
      r.line_break  = 1'b1;
      r.last_of_run = 1'b1;
      pending_glyphs.push_back(r);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
      if (row_pos >= h) row_pos = 0;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Pixel driver: bursts of idle cycles, payload held until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready_o === 1'b1) begin
        predict_glyphs(in_data);
      end
      if (!in_valid || in_ready_o === 1'b1) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Word monitor: random stall bursts, compare against oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o === 1'b1 && out_ready) begin
        if (pending_glyphs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] unexpected word: glyph %0d rgb %0d/%0d/%0d brk %0b last %0b",
                     $realtime, out_data_o.glyph, out_data_o.out_red,
                     out_data_o.out_green, out_data_o.out_blue,
                     out_data_o.line_break, out_data_o.last_of_run);
        end else begin
          want = pending_glyphs.pop_front();
          if (out_data_o.glyph !== want.glyph || out_data_o.out_red !== want.out_red ||
              out_data_o.out_green !== want.out_green ||
              out_data_o.out_blue !== want.out_blue ||
              out_data_o.line_break !== want.line_break ||
              out_data_o.last_of_run !== want.last_of_run) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("[%0t] mismatch: expected glyph %0d rgb %0d/%0d/%0d brk %0b last %0b",
                       $realtime, want.glyph, want.out_red, want.out_green,
                       want.out_blue, want.line_break, want.last_of_run);
              $display("[%0t]           actual glyph %0d rgb %0d/%0d/%0d brk %0b last %0b",
                       $realtime, out_data_o.glyph, out_data_o.out_red,
                       out_data_o.out_green, out_data_o.out_blue,
                       out_data_o.line_break, out_data_o.last_of_run);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("pixel_to_ascii_glyph_stream_top_tb failed");
      $finish;
    end
  end

  // Block until no pixel is queued or in flight and every word has come out
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid || pending_glyphs.size() != 0);
  endtask

  // Register write while idle; any write restarts the raster
  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) img_w = val;
    else img_h = val;
    col_pos = 0;
    row_pos = 0;
    @(negedge clk_i);
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pxa_pix_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pixel_q.push_back(px);
  endtask

  // Channel value biased toward the extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      queue_pixel(rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  // Dimension at or beyond the clamp points, or a random one
  function automatic logic [DIM_W-1:0] corner_dim();
    case ($urandom_range(0, 4))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4096;
      3:       return 13'd8191;
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  // Stimulus sequence
  initial begin
    int unsigned rand_items;
    int unsigned n;
    int unsigned pick;
    rand_items = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size 640x480: column step 5, so only the first pixel makes a glyph
    queue_pixel(8'h12, 8'h34, 8'h56);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'h80, 8'h80, 8'h80);

    // 1x1 image: every pixel gives a glyph followed by a line break
    write_dim(REG_WIDTH, 13'd1);
    write_dim(REG_HEIGHT, 13'd1);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hFF, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'hFF, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'hFF);
    queue_pixel(8'hAA, 8'h55, 8'hAA);
    queue_pixel(8'h55, 8'hAA, 8'h55);
    queue_pixel(8'h01, 8'h80, 8'hFE);

    // Zero dimensions read as one
    write_dim(REG_WIDTH, 13'd0);
    write_dim(REG_HEIGHT, 13'd0);
    queue_pixel(8'h7F, 8'h7F, 8'h7F);
    queue_pixel(8'h40, 8'hC0, 8'h20);

    // 3x2 image, one pixel past the end to see the wrap
    write_dim(REG_WIDTH, 13'd3);
    write_dim(REG_HEIGHT, 13'd2);
    queue_random(7);

    // Oversize dimensions clamp to the maximum
    write_dim(REG_WIDTH, 13'd8191);
    write_dim(REG_HEIGHT, 13'd8191);
    queue_random(3);

    // Random phases with varied geometry
    while (rand_items < RAND_ITEMS) begin
      if (rand_items + 120 >= RAND_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 9);
      n = $urandom_range(10, 80);
      case (pick)
        5: begin
          // row step above one: unsampled rows in between
          write_dim(REG_WIDTH, 13'($urandom_range(1, 6)));
          write_dim(REG_HEIGHT, 13'($urandom_range(80, 200)));
          n = $urandom_range(40, 160);
        end
        6: begin
          // column step above one on long rows
          write_dim(REG_WIDTH, 13'($urandom_range(240, 370)));
          write_dim(REG_HEIGHT, 13'($urandom_range(1, 3)));
          n = $urandom_range(250, 450);
        end
        7: begin
          write_dim(REG_WIDTH, corner_dim());
          write_dim(REG_HEIGHT, corner_dim());
        end
        8: begin
          write_dim(1'($urandom_range(0, 1)), 13'($urandom_range(1, 16)));
        end
        9: begin
          // sender holds off until everything has drained, image continues
          wait_idle();
        end
        default: begin
          write_dim(REG_WIDTH, 13'($urandom_range(1, 12)));
          write_dim(REG_HEIGHT, 13'($urandom_range(1, 6)));
        end
      endcase
      // keep the total close to the planned item count
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      queue_random(n);
      rand_items += n;
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_glyphs.size() == 0) begin
      $display("pixel_to_ascii_glyph_stream_top_tb passed");
    end else begin
      $display("pixel_to_ascii_glyph_stream_top_tb failed");
    end
    $finish;
  end

endmodule
